@@ rtl/core/ufsm_pkg.sv @@
// shared widths and request codes for the union-find set merger
`default_nettype none

package ufsm_pkg;

    // width of an element index on the request port
    localparam int unsigned RAW_W = 10;

    // width of the set size on the result port
    localparam int unsigned SIZE_W = 11;

    // width of the epoch tag kept with every stored element
    localparam int unsigned EPOCH_W = 8;

    // request opcodes
    localparam logic OP_UNITE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/ufsm_wrap.sv @@
// index reduction modulo the element count, one compare and subtract per cycle
`default_nettype none

module ufsm_wrap #(
    parameter int unsigned NUM_ELEMS = 1024,
    parameter int unsigned IDX_W     = 10
) (
    input  wire logic                      clk,
    input  wire logic                      load,
    input  wire logic [ufsm_pkg::RAW_W-1:0] raw,
    output logic      [IDX_W-1:0]          idx,
    output logic                           fit
);

    localparam int unsigned SH_W = $clog2(ufsm_pkg::RAW_W);

    logic [ufsm_pkg::RAW_W-1:0] val_reg;
    logic [ufsm_pkg::RAW_W-1:0] val_next;
    logic [SH_W-1:0]            sh_reg;
    logic [SH_W-1:0]            sh_next;
    logic [31:0]                step_val;

    assign fit      = (32'(val_reg) < 32'(NUM_ELEMS));
    assign idx      = IDX_W'(val_reg);
    assign step_val = 32'(NUM_ELEMS) << sh_reg;

    always_comb
    begin
        val_next = val_reg;
        sh_next  = sh_reg;
        if (load)
        begin
            val_next = raw;
            sh_next  = SH_W'(ufsm_pkg::RAW_W - 1);
        end
        else if (!fit)
        begin
            // only reached when the count is below the raw index range
            // take shifted multiples of the count off, largest first
            if (32'(val_reg) >= step_val)
            begin
                val_next = val_reg - ufsm_pkg::RAW_W'(step_val);
            end
            if (sh_reg != '0)
            begin
                sh_next = sh_reg - SH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sh_reg  <= sh_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/union_find_set_merger_unit.sv @@
// union-find set merger: disjoint sets in one node memory, union by size, path compression
//
//  channel  | direction | handshake            | fields
//  ---------+-----------+----------------------+---------------------------
//  request  | in        | req_valid, req_stall | opcode, elem_a, elem_b
//  result   | out       | res_valid, res_stall | set_size
//
// a unite request holds the input while the root of each element is found, the path from each
// element is relinked to its root, and, when the roots differ, the smaller root goes under the larger;
// union by size keeps each element within log2 of NUM_ELEMS links of its root.
// below 1024 elements an index of NUM_ELEMS or more is first reduced, which holds the input longer.
// a clear request holds the input only when it starts a sweep: every 255th clear and reset sweep the memory.
// a finished result waits in the output register while a new request is taken; a second
// finished result holds req_stall high until the output register frees up.
`default_nettype none

module union_find_set_merger_unit #(
    parameter int unsigned NUM_ELEMS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic                        opcode,
    input  wire logic [ufsm_pkg::RAW_W-1:0]  elem_a,
    input  wire logic [ufsm_pkg::RAW_W-1:0]  elem_b,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic      [ufsm_pkg::SIZE_W-1:0] set_size
);

    localparam int unsigned IDX_W = $clog2(NUM_ELEMS);
    localparam int unsigned CNT_W = $clog2(NUM_ELEMS + 1);

    typedef struct packed {
        logic [ufsm_pkg::EPOCH_W-1:0] tag;
        logic [IDX_W-1:0]             parent;
        logic [CNT_W-1:0]             cnt;
    } node_t;

    typedef enum logic [9:0] {
        S_SWEEP   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_WRAP    = 10'b0000000100,
        S_FIND_RD = 10'b0000001000,
        S_WALK    = 10'b0000010000,
        S_COMP_RD = 10'b0000100000,
        S_COMP    = 10'b0001000000,
        S_MERGE   = 10'b0010000000,
        S_MERGE2  = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [ufsm_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]             sweep_reg, sweep_next;
    logic                         phase_reg, phase_next;
    logic [IDX_W-1:0]             walk_reg, walk_next;
    logic [IDX_W-1:0]             root_reg, root_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [IDX_W-1:0]             root_a_reg, root_a_next;
    logic [CNT_W-1:0]             cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]             sum_reg, sum_next;
    logic                         res_valid_reg, res_valid_next;
    logic [ufsm_pkg::SIZE_W-1:0]  size_reg, size_next;

    node_t                        node_store_reg [NUM_ELEMS];
    node_t                        rd_word_reg;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [IDX_W-1:0]             mem_raddr;
    node_t                        mem_wdata;

    logic                         req_accept;
    logic                         wrap_load;
    logic [IDX_W-1:0]             idx_a, idx_b, cur_x;
    logic                         fit_a, fit_b;
    logic                         phase_done;
    logic [IDX_W-1:0]             fin_root;
    logic [CNT_W-1:0]             fin_cnt;
    logic                         b_under;
    logic [IDX_W-1:0]             new_root;
    logic [IDX_W-1:0]             child;
    logic [CNT_W-1:0]             child_cnt;
    logic [ufsm_pkg::EPOCH_W-1:0] epoch_inc;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign wrap_load  = req_accept && (opcode == ufsm_pkg::OP_UNITE);
    assign res_valid  = res_valid_reg;
    assign set_size   = size_reg;
    assign cur_x      = phase_reg ? idx_b : idx_a;
    assign epoch_inc  = epoch_reg + ufsm_pkg::EPOCH_W'(1);

    // on equal sizes the second root goes under the first
    assign b_under   = !(cnt_a_reg < cnt_reg);
    assign new_root  = b_under ? root_a_reg : root_reg;
    assign child     = b_under ? root_reg : root_a_reg;
    assign child_cnt = b_under ? cnt_reg : cnt_a_reg;

    ufsm_wrap #(
        .NUM_ELEMS (NUM_ELEMS),
        .IDX_W     (IDX_W)
    ) u_wrap_a (
        .clk  (clk),
        .load (wrap_load),
        .raw  (elem_a),
        .idx  (idx_a),
        .fit  (fit_a)
    );

    ufsm_wrap #(
        .NUM_ELEMS (NUM_ELEMS),
        .IDX_W     (IDX_W)
    ) u_wrap_b (
        .clk  (clk),
        .load (wrap_load),
        .raw  (elem_b),
        .idx  (idx_b),
        .fit  (fit_b)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_store_reg[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= node_store_reg[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        phase_next     = phase_reg;
        walk_next      = walk_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        root_a_next    = root_a_reg;
        cnt_a_next     = cnt_a_reg;
        sum_next       = sum_reg;
        res_valid_next = res_valid_reg;
        size_next      = size_reg;
        mem_we         = 1'b0;
        mem_waddr      = walk_reg;
        mem_raddr      = walk_reg;
        mem_wdata      = '0;
        phase_done     = 1'b0;
        fin_root       = root_reg;
        fin_cnt        = cnt_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                // tag zero never matches a live epoch
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                sweep_next = sweep_reg + IDX_W'(1);
                if (32'(sweep_reg) == 32'(NUM_ELEMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (opcode == ufsm_pkg::OP_CLEAR)
                    begin
                        if (epoch_inc == '0)
                        begin
                            epoch_next = ufsm_pkg::EPOCH_W'(1);
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_inc;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP:
            begin
                if (fit_a && fit_b)
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                mem_raddr  = cur_x;
                walk_next  = cur_x;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (rd_word_reg.tag != epoch_reg)
                begin
                    // first touch: the element becomes a root of its own
                    mem_we         = 1'b1;
                    mem_waddr      = cur_x;
                    mem_wdata.tag    = epoch_reg;
                    mem_wdata.parent = cur_x;
                    mem_wdata.cnt    = CNT_W'(1);
                    root_next  = cur_x;
                    cnt_next   = CNT_W'(1);
                    fin_root   = cur_x;
                    fin_cnt    = CNT_W'(1);
                    phase_done = 1'b1;
                end
                else if (rd_word_reg.parent == walk_reg)
                begin
                    root_next = walk_reg;
                    cnt_next  = rd_word_reg.cnt;
                    fin_root  = walk_reg;
                    fin_cnt   = rd_word_reg.cnt;
                    if (walk_reg == cur_x)
                    begin
                        phase_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_COMP_RD;
                    end
                end
                else
                begin
                    walk_next = rd_word_reg.parent;
                    mem_raddr = rd_word_reg.parent;
                end
            end
            S_COMP_RD:
            begin
                mem_raddr  = cur_x;
                walk_next  = cur_x;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                // relink this node while the next one on the path is read
                mem_we           = 1'b1;
                mem_waddr        = walk_reg;
                mem_wdata.tag    = rd_word_reg.tag;
                mem_wdata.parent = root_reg;
                mem_wdata.cnt    = rd_word_reg.cnt;
                if (rd_word_reg.parent == root_reg)
                begin
                    phase_done = 1'b1;
                end
                else
                begin
                    walk_next = rd_word_reg.parent;
                    mem_raddr = rd_word_reg.parent;
                end
            end
            S_MERGE:
            begin
                if (root_a_reg == root_reg)
                begin
                    sum_next   = cnt_a_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = child;
                    mem_wdata.tag    = epoch_reg;
                    mem_wdata.parent = new_root;
                    mem_wdata.cnt    = child_cnt;
                    sum_next         = cnt_a_reg + cnt_reg;
                    state_next       = S_MERGE2;
                end
            end
            S_MERGE2:
            begin
                mem_we           = 1'b1;
                mem_waddr        = new_root;
                mem_wdata.tag    = epoch_reg;
                mem_wdata.parent = new_root;
                mem_wdata.cnt    = sum_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    size_next      = ufsm_pkg::SIZE_W'(sum_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (phase_done)
        begin
            if (!phase_reg)
            begin
                root_a_next = fin_root;
                cnt_a_next  = fin_cnt;
                phase_next  = 1'b1;
                state_next  = S_FIND_RD;
            end
            else
            begin
                state_next = S_MERGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            epoch_reg     <= ufsm_pkg::EPOCH_W'(1);
            sweep_reg     <= '0;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg   <= walk_next;
        root_reg   <= root_next;
        cnt_reg    <= cnt_next;
        root_a_reg <= root_a_next;
        cnt_a_reg  <= cnt_a_next;
        sum_reg    <= sum_next;
        size_reg   <= size_next;
    end

    // a live epoch is never the sweep tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SWEEP) |-> (epoch_reg != '0))
        else $error("epoch tag zero outside sweep");

    // compression never reads the entry it is rewriting in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && !phase_done) |-> (mem_raddr != mem_waddr))
        else $error("read and write of one node in one cycle");

    // a new result only comes out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // merged size stays within the element count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (sum_reg != '0 && 32'(sum_reg) <= 32'(NUM_ELEMS)))
        else $error("set size out of range");

endmodule

`default_nettype wire
